// ===== design/apa_pkg.sv =====
// ----------------------------------------------------------------------------
// apa_pkg: shared constants and types for the polygon area accumulator
// Holds the default parameter values and the operation codes that the
// sequencer issues to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package apa_pkg;

    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int ROOT_STEPS_DEF      = 32;

    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_ARC  = 2'd1;
    localparam logic [1:0] TURN_POS  = 2'd1;
    localparam logic [1:0] TURN_NEG  = 2'd2;

    // Operations of the shared iterative unit.
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,   // a * b, 64x64, one 32x32 partial product a cycle
        OP_DIV  = 2'd1,   // floor(n / d), 128/64, one quotient bit a cycle
        OP_SQRT = 2'd2    // floor(sqrt(n)), 128 -> 64, one root bit a cycle
    } t_op;

    typedef struct packed {
        logic       start;
        t_op        op;
        logic [127:0] n;
        logic [63:0]  d;
    } t_unit_req;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } t_unit_rsp;

endpackage

// ===== design/arc_polygon_area_accumulator.sv =====
// ----------------------------------------------------------------------------
// arc_polygon_area_accumulator: shoelace area sum with circular arcs
// One boundary curve per item; the saturated Q32.32 total leaves with the
// item marked last, and the sum clears.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  input   | in        | i_valid / o_stall         | kind, src/dst x,y, radius_sq, turn, last
//  output  | out       | o_valid / i_stall         | total_area, saturated
//
//  Every operation (multiply, divide, square root) runs through one shared
//  unit. Other kinds go straight to the sum, a straight curve needs one
//  multiply, and an arc needs up to 9 + 2*ROOT_STEPS unit operations.
//  Reset is synchronous; it clears the sum, the clip flag and the sequencer.
//  o_stall is high while a curve is in work; a last curve whose total finds
//  the previous total still waiting holds in the sum state until it leaves.
//  Coordinates are Q16.16 and the sum carries twice as many fraction bits.
// ----------------------------------------------------------------------------
module arc_polygon_area_accumulator
    import apa_pkg::*;
#(
    parameter int ROOT_STEPS      = ROOT_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_src_x,
    input  logic signed [31:0] i_src_y,
    input  logic signed [31:0] i_dst_x,
    input  logic signed [31:0] i_dst_y,
    input  logic [62:0]        i_radius_sq,
    input  logic [1:0]         i_turn,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [63:0] o_total_area,
    output logic               o_saturated
);

    localparam int SW = $clog2(ROOT_STEPS + 1);
    localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

    typedef enum logic [4:0] {
        S_IDLE, S_TRAP, S_DXDX, S_DYDY, S_CHK, S_S2, S_S, S_C, S_TRI_M,
        S_TRI_R, S_LOOP_C, S_LOOP_T, S_SECT, S_SUM, S_OUT
    } t_state;

    t_state       r_state;
    logic         r_wait;
    t_unit_req    r_req;
    t_unit_rsp    w_rsp;

    logic [1:0]   r_kind, r_turn;
    logic         r_last;
    logic [62:0]  r_r;
    logic [32:0]  r_adx, r_ady, r_asy;
    logic         r_neg_tr;
    logic [127:0] r_q;
    logic [127:0] r_contrib;
    logic [63:0]  r_s2, r_c, r_t, r_tri;
    logic [SW-1:0] r_k;
    logic [63:0]  r_sum;
    logic         r_clip;
    logic         r_ovalid;
    logic [63:0]  r_oarea;
    logic         r_osat;

    logic signed [32:0] w_dx, w_dy, w_sy;
    logic [127:0] w_four_r;
    logic [127:0] w_tri_b;
    logic [127:0] w_sum;
    logic [127:0] w_seg;

    apa_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (w_rsp)
    );

    always_comb begin
        w_dx = 33'(i_src_x) - 33'(i_dst_x);
        w_dy = 33'(i_src_y) - 33'(i_dst_y);
        w_sy = 33'(i_src_y) + 33'(i_dst_y);
        w_four_r = {63'd0, r_r, 2'd0};
        w_tri_b  = w_four_r - r_q;
        w_sum = {{64{r_sum[63]}}, r_sum} + r_contrib;
        // segment = sector - tri; sector sits in r_t after S_SECT
        w_seg = {64'd0, r_t} - {64'd0, r_tri};
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_total_area = r_oarea;
    assign o_saturated  = r_osat;

    // Sequencer: issue one unit operation, wait for done, consume result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_req.start <= 1'b0;
            r_sum    <= '0;
            r_clip   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // start is a one-cycle pulse; no request goes out while r_wait is set
            if (r_req.start) r_req.start <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_kind <= i_kind;
                        r_turn <= i_turn;
                        r_last <= i_last;
                        r_r    <= i_radius_sq;
                        r_adx  <= w_dx[32] ? 33'(-w_dx) : w_dx;
                        r_ady  <= w_dy[32] ? 33'(-w_dy) : w_dy;
                        r_asy  <= w_sy[32] ? 33'(-w_sy) : w_sy;
                        r_neg_tr <= w_dx[32] ^ w_sy[32];
                        r_contrib <= '0;
                        r_wait <= 1'b0;
                        r_state <= (i_kind[1]) ? S_SUM : S_TRAP;
                    end
                end
                S_TRAP: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_MUL, {95'd0, r_adx}, {31'd0, r_asy}};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        if (r_neg_tr) begin
                            r_contrib <= $signed(128'(-w_rsp.res)) >>> 1;
                        end else begin
                            r_contrib <= w_rsp.res >> 1;
                        end
                        r_state <= (r_kind == KIND_ARC &&
                                    (r_turn == TURN_POS || r_turn == TURN_NEG))
                                   ? S_DXDX : S_SUM;
                    end
                end
                S_DXDX: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_MUL, {95'd0, r_adx}, {31'd0, r_adx}};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_q <= w_rsp.res;
                        r_state <= S_DYDY;
                    end
                end
                S_DYDY: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_MUL, {95'd0, r_ady}, {31'd0, r_ady}};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_q <= r_q + w_rsp.res;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_tri <= '0;
                    r_k   <= '0;
                    if (r_r == 63'd0 || w_four_r <= r_q) begin
                        r_t <= ONE_Q62;
                        r_c <= '0;
                        r_state <= S_LOOP_C;
                    end else begin
                        r_state <= S_S2;
                    end
                end
                S_S2: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_DIV, r_q << 60, {1'b0, r_r}};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_s2 <= w_rsp.res[63:0];
                        r_state <= S_S;
                    end
                end
                S_S: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_SQRT, {64'd0, r_s2} << 62, 64'd0};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_t <= w_rsp.res[63:0];
                        r_state <= S_C;
                    end
                end
                S_C: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_SQRT, {64'd0, ONE_Q62 - r_s2} << 62, 64'd0};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_c <= w_rsp.res[63:0];
                        r_state <= S_TRI_M;
                    end
                end
                S_TRI_M: begin
                    // q and 4R - q fit 65 bits and never both reach 2^64; the
                    // unit multiplies the low halves, the top bit is folded in here
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_MUL, {64'd0, r_q[63:0]}, w_tri_b[63:0]};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_q <= w_rsp.res
                               + (r_q[64] ? {w_tri_b[63:0], 64'd0} : 128'd0)
                               + (w_tri_b[64] ? {r_q[63:0], 64'd0} : 128'd0);
                        r_state <= S_TRI_R;
                    end
                end
                S_TRI_R: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_SQRT, r_q, 64'd0};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_tri <= w_rsp.res[63:0] >> 2;
                        r_state <= S_LOOP_C;
                    end
                end
                S_LOOP_C: begin
                    if (r_k == SW'(ROOT_STEPS)) begin
                        r_state <= S_SECT;
                    end else if (!r_wait) begin
                        r_req <= '{1'b1, OP_SQRT,
                                   {64'd0, 64'((65'(ONE_Q62) + 65'(r_c)) >> 1)} << 62, 64'd0};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_c <= w_rsp.res[63:0];
                        r_state <= S_LOOP_T;
                    end
                end
                S_LOOP_T: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_DIV, {64'd0, r_t} << 62, r_c};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_t <= w_rsp.res[63:0];
                        r_k <= r_k + SW'(1);
                        r_state <= S_LOOP_C;
                    end
                end
                S_SECT: begin
                    if (!r_wait) begin
                        r_req <= '{1'b1, OP_MUL, {65'd0, r_r}, r_t};
                        r_wait <= 1'b1;
                    end else if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_t <= w_rsp.res[125:62];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // fold the segment term into the contribution
                    r_contrib <= (r_turn == TURN_NEG) ? r_contrib - w_seg
                                                      : r_contrib + w_seg;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    logic [63:0] v_sum;
                    logic        v_clip;
                    v_clip = !((w_sum[127:63] == '0) || (w_sum[127:63] == '1));
                    v_sum  = v_clip ? (w_sum[127] ? 64'h8000_0000_0000_0000
                                                  : 64'h7fff_ffff_ffff_ffff)
                                    : w_sum[63:0];
                    // a new total waits here while the previous one is still held
                    if (!(r_last && r_ovalid)) begin
                        if (r_last) begin
                            r_ovalid <= 1'b1;
                            r_oarea  <= v_sum;
                            r_osat   <= r_clip | v_clip;
                            r_sum    <= '0;
                            r_clip   <= 1'b0;
                        end else begin
                            r_sum  <= v_sum;
                            r_clip <= r_clip | v_clip;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/apa_unit.sv =====
// ----------------------------------------------------------------------------
// apa_unit: shared multiply / divide / square-root unit
// Multiply runs four 32x32 partial products; divide and root are
// restoring, one result bit per cycle.
// ----------------------------------------------------------------------------
module apa_unit
    import apa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    logic         r_busy;
    t_op          r_op;
    logic [6:0]   r_cnt;
    logic [127:0] r_n;
    logic [63:0]  r_d;
    logic [127:0] r_acc;     // product, or partial remainder
    logic [63:0]  r_q;       // quotient or root
    logic         r_done;

    logic [31:0]  w_ma, w_mb;
    logic [63:0]  w_pp;
    logic [127:0] w_ppsh;
    logic [5:0]   w_bit;
    logic [63:0]  w_cand;
    logic [127:0] w_sq;
    logic [127:0] w_dtest;
    logic         w_div_ok;

    // multiply: partial product select
    always_comb begin
        w_ma   = r_cnt[0] ? r_n[63:32] : r_n[31:0];
        w_mb   = r_cnt[1] ? r_d[63:32] : r_d[31:0];
        w_pp   = {32'd0, w_ma} * {32'd0, w_mb};
        w_ppsh = {64'd0, w_pp} << (({6'd0, r_cnt[0]} + {6'd0, r_cnt[1]}) * 7'd32);
    end

    // divide/sqrt: restoring step. r_acc holds running remainder for divide;
    // for root we test (q | bit)^2 incrementally: (q+b)^2 = q^2 + 2qb + b^2.
    always_comb begin
        w_bit   = 6'(63 - r_cnt[5:0]);
        w_cand  = r_q | (64'd1 << w_bit);
        // root: r_acc = n - q^2; need 2*q*b + b^2 <= r_acc
        w_sq    = ({64'd0, r_q} << ({1'b0, w_bit} + 7'd1)) | (128'd1 << ({1'b0, w_bit} * 7'd2));
        // divide: r_acc = n - q*d; need d*b <= r_acc
        w_dtest = {64'd0, r_d} << w_bit;
        w_div_ok = (r_d != 64'd0) && (w_dtest <= r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_n    <= i_req.n;
                r_d    <= i_req.d;
                r_cnt  <= '0;
                r_q    <= '0;
                r_acc  <= (i_req.op == OP_MUL) ? 128'd0 : i_req.n;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                unique case (r_op)
                    OP_MUL: begin
                        r_acc <= r_acc + w_ppsh;
                        if (r_cnt == 7'd3) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    OP_DIV, OP_SQRT: begin
                        if (r_op == OP_DIV) begin
                            if (w_div_ok) begin
                                r_acc <= r_acc - w_dtest;
                                r_q   <= w_cand;
                            end
                        end else if (w_sq <= r_acc) begin
                            r_acc <= r_acc - w_sq;
                            r_q   <= w_cand;
                        end
                        if (r_cnt == 7'd63) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: r_busy <= 1'b0;
                endcase
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == OP_MUL) ? r_acc : {64'd0, r_q};

endmodule
